@@ hw/rtl/ssr_pkg.sv @@
`timescale 1ns / 1ps
package ssr_pkg;

	localparam int BLOCK_MAX_DEF = 256;
	localparam int SAMPLE_W = 16;
	localparam int RAW_W = 32;
	localparam int SHAMT_W = 5;
	localparam int ROOT_W = 16;
	localparam int RAD_W = 32;

	localparam logic [SHAMT_W-1:0] SHAMT_RESET = 5'd14;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;
	localparam logic [ROOT_W:0] RMS_LIMIT = 17'd32768;

	typedef struct packed {
		logic signed [RAW_W-1:0] raw_sample;
		logic                    last_sample;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic [ROOT_W-1:0]          rms;
		logic                       rms_valid;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SQUARE,
		ST_CLOSE,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage

@@ hw/rtl/ssr_scale.sv @@
`timescale 1ns / 1ps
module ssr_scale import ssr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [RAW_W-1:0]    raw,
	input  logic [SHAMT_W-1:0]         shamt,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] sample
);

	logic [RAW_W-1:0]   word_q;
	logic [SHAMT_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [RAW_W-SAMPLE_W:0] hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one bit of arithmetic shift per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= raw;
			cnt_q <= shamt;
		end else if (busy_q && cnt_q != '0) begin
			word_q <= {word_q[RAW_W-1], word_q[RAW_W-1:1]};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign hi = word_q[RAW_W-1:SAMPLE_W-1];

	always_comb begin
		if (&hi || ~|hi) begin
			sample = word_q[SAMPLE_W-1:0];
		end else if (word_q[RAW_W-1]) begin
			sample = SAT_MIN;
		end else begin
			sample = SAT_MAX;
		end
	end

	assign done = done_q;

endmodule

@@ hw/rtl/ssr_div.sv @@
`timescale 1ns / 1ps
module ssr_div import ssr_pkg::*; #(
	parameter int SUM_W = 39,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	localparam int CW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   rem_sh;
	logic [CNT_W:0]   rem_nx;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			cnt_q <= CW'(SUM_W - 1);
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_nx[CNT_W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/ssr_sqrt.sv @@
`timescale 1ns / 1ps
module ssr_sqrt import ssr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;
	localparam int CW = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  rem_t;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  rem_nx;
	logic              ge;

	// restoring square root, two radicand bits per cycle
	assign rem_t = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge = rem_t >= trial;
	assign rem_nx = ge ? (rem_t - trial) : rem_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
			cnt_q <= CW'(ROOT_W - 1);
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q <= rem_nx[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ hw/rtl/sample_scale_saturate_block_rms.sv @@
`timescale 1ns / 1ps
// Block RMS level meter.
// Input channel in_valid/in_stall/in_data carries one raw 32-bit sample and a
// last-of-block flag per transaction. Output channel out_valid/out_stall/out_data
// returns exactly one transaction per input: the sample shifted right by
// shift_amount and saturated to 16 bits, plus rms/rms_valid when the input
// closes a block (last flag set, or BLOCK_MAX samples counted).
// One input transaction is processed at a time. A sample that does not close
// a block passes through the serial shifter, then a shift-add square into the
// energy sum. A closing sample adds a bit-serial divide and a 16-step square
// root.
// An output register sits between the two sides: the next input is accepted
// while a finished result still waits in it; when out_stall holds the result,
// the following item stops in its final step until the register frees up.
// shift_amount is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which it does not enforce. Reset clears the energy
// sum and sample count, sets shift_amount to 14 and empties the output register.
module sample_scale_saturate_block_rms import ssr_pkg::*; #(
	parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SHAMT_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_data
);

	localparam int CNT_W = $clog2(BLOCK_MAX + 1);
	localparam int SUM_W = 31 + $clog2(BLOCK_MAX);
	localparam int ADD_W = 2 * SAMPLE_W - 1;
	localparam logic [CNT_W-1:0] BMAX = CNT_W'(BLOCK_MAX);

	state_t state_q, state_nx;

	logic [SHAMT_W-1:0]  shamt_q;
	logic [SUM_W-1:0]    energy_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_inc;
	logic                close_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic [ADD_W-1:0]    addend_q;
	logic [3:0]          bit_q;
	logic                out_valid_q;
	out_t                out_data_q;

	logic                       accept;
	logic                       load_out;
	logic                       scale_start;
	logic                       scale_done;
	logic                       div_start;
	logic                       div_done;
	logic                       sqrt_start;
	logic                       sqrt_done;
	logic signed [SAMPLE_W-1:0] scale_sample;
	logic [SAMPLE_W-1:0]        mag_nx;
	logic [SUM_W-1:0]           quotient;
	logic [ROOT_W-1:0]          root;

	assign accept = in_valid && !in_stall;
	assign count_inc = count_q + 1'b1;
	assign mag_nx = scale_sample[SAMPLE_W-1] ? (~scale_sample + 1'b1) : scale_sample;

	ssr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.raw    (in_data.raw_sample),
		.shamt  (shamt_q),
		.done   (scale_done),
		.sample (scale_sample)
	);

	ssr_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (energy_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	ssr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({1'b0, quotient[RAD_W-2:0]}),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		in_stall = 1'b1;
		scale_start = 1'b0;
		div_start = 1'b0;
		sqrt_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					scale_start = 1'b1;
					state_nx = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scale_done) begin
					state_nx = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (bit_q == 4'd15) begin
					state_nx = close_q ? ST_CLOSE : ST_OUT;
				end
			end
			ST_CLOSE: begin
				div_start = 1'b1;
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					sqrt_start = 1'b1;
					state_nx = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shamt_q <= SHAMT_RESET;
			energy_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				shamt_q <= cfg_wdata;
			end
			if (accept) begin
				count_q <= count_inc;
			end
			if (state_q == ST_SQUARE && mag_q[0]) begin
				energy_q <= energy_q + SUM_W'(addend_q);
			end
			// divider has latched sum and count
			if (state_q == ST_CLOSE) begin
				energy_q <= '0;
				count_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			close_q <= in_data.last_sample || (count_inc == BMAX);
		end
		if (state_q == ST_SCALE && scale_done) begin
			mag_q <= mag_nx;
			addend_q <= ADD_W'(mag_nx);
			bit_q <= '0;
		end else if (state_q == ST_SQUARE) begin
			mag_q <= {1'b0, mag_q[SAMPLE_W-1:1]};
			addend_q <= {addend_q[ADD_W-2:0], 1'b0};
			bit_q <= bit_q + 1'b1;
		end
		if (load_out) begin
			out_data_q.sample_out <= scale_sample;
			out_data_q.rms <= close_q ? root : '0;
			out_data_q.rms_valid <= close_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("output loaded outside final step");

	a_rms_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.rms_valid |-> out_data_q.rms == '0)
		else $error("rms nonzero on non-closing transaction");

	a_rms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> {1'b0, out_data_q.rms} <= RMS_LIMIT)
		else $error("rms out of range");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> count_q < BMAX)
		else $error("sample count reached block size without closing");

	a_div_close: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> close_q && count_q != '0)
		else $error("divide started without a closing block");

endmodule
